@@ src/lesdp_pkg.sv @@
// Shared types and constants for the largest empty square finder.
`timescale 1ns / 1ps
`default_nettype none
package lesdp_pkg;

   localparam int VALUE_W = 11;
   localparam int POS_W   = 10;
   localparam int LEN_W   = 11;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
   localparam logic [LEN_W-1:0]   ROW_LENGTH_RESET = LEN_W'(1);

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   typedef struct packed {
      logic cell_free;
      logic last_cell;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] best_size;
      logic [POS_W-1:0]   best_row;
      logic [POS_W-1:0]   best_col;
   } rsp_type;

   // Control carried from the sequencer into the update stage.
   typedef struct packed {
      logic valid;
      logic last;
      logic free;
      logic on_border;
      logic fwd;
   } ctl_type;

endpackage
`default_nettype wire

@@ src/lesdp_seq.sv @@
// Column and row sequencer: issues the line buffer read and stages each item.
`timescale 1ns / 1ps
`default_nettype none
module lesdp_seq #(
   parameter int MAX_WIDTH  = lesdp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lesdp_pkg::DEF_MAX_HEIGHT,
   parameter int COL_W      = 10,
   parameter int ROW_W      = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire lesdp_pkg::req_type         item,
   input  wire logic [lesdp_pkg::LEN_W-1:0] row_length,
   output logic [COL_W-1:0]                rd_addr,
   output lesdp_pkg::ctl_type              ctl_ff,
   output logic [COL_W-1:0]                col_ff,
   output logic [ROW_W-1:0]                row_ff
);

   localparam int CMP_W = (COL_W + 1 > lesdp_pkg::LEN_W) ? COL_W + 1 : lesdp_pkg::LEN_W;
   localparam logic [CMP_W-1:0] WIDTH_LIM = CMP_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);

   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [CMP_W-1:0] len_c;
   logic [CMP_W-1:0] col_next;
   logic [COL_W-1:0] col_c;
   logic [ROW_W-1:0] row_c;
   logic             wrap_pre;
   logic             wrap_post;
   lesdp_pkg::ctl_type ctl_in;

   function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
      return (r < ROW_LAST) ? r + ROW_W'(1) : r;
   endfunction

   always_comb begin
      if (row_length == '0) begin
         len_c = CMP_W'(1);
      end else if (CMP_W'(row_length) > WIDTH_LIM) begin
         len_c = WIDTH_LIM;
      end else begin
         len_c = CMP_W'(row_length);
      end

      // A shorter row length than the current column starts a new row here.
      wrap_pre = CMP_W'(col_cnt_ff) >= len_c;
      col_c    = wrap_pre ? '0 : col_cnt_ff;
      row_c    = wrap_pre ? row_step(row_cnt_ff) : row_cnt_ff;
      col_next  = CMP_W'(col_c) + CMP_W'(1);
      wrap_post = col_next >= len_c;

      if (item.last_cell) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (wrap_post) begin
         col_cnt_in = '0;
         row_cnt_in = row_step(row_c);
      end else begin
         col_cnt_in = col_next[COL_W-1:0];
         row_cnt_in = row_c;
      end

      ctl_in.valid     = accept;
      ctl_in.last      = item.last_cell;
      ctl_in.free      = item.cell_free;
      ctl_in.on_border = (row_c == '0) || (col_c == '0);
      // The item ahead writes this same entry in this cycle.
      ctl_in.fwd       = ctl_ff.valid && (col_ff == col_c);
   end

   assign rd_addr = col_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
      end
      if (accept) begin
         ctl_ff.last      <= ctl_in.last;
         ctl_ff.free      <= ctl_in.free;
         ctl_ff.on_border <= ctl_in.on_border;
         ctl_ff.fwd       <= ctl_in.fwd;
         col_ff           <= col_c;
         row_ff           <= row_c;
      end
   end

endmodule
`default_nettype wire

@@ src/lesdp_linebuf.sv @@
// Line buffer holding the previous row's square sizes.
`timescale 1ns / 1ps
`default_nettype none
module lesdp_linebuf #(
   parameter int DEPTH  = lesdp_pkg::DEF_MAX_WIDTH,
   parameter int ADDR_W = 10
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic [lesdp_pkg::VALUE_W-1:0]      rd_data,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [lesdp_pkg::VALUE_W-1:0] wr_data
);

   logic [lesdp_pkg::VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ src/lesdp_cell.sv @@
// Square size update, line buffer write-back and best square tracking.
`timescale 1ns / 1ps
`default_nettype none
module lesdp_cell #(
   parameter int COL_W = 10,
   parameter int ROW_W = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lesdp_pkg::ctl_type            ctl,
   input  wire logic [COL_W-1:0]              col,
   input  wire logic [ROW_W-1:0]              row,
   input  wire logic [lesdp_pkg::VALUE_W-1:0] rd_data,
   output logic                               wr_en,
   output logic [COL_W-1:0]                   wr_addr,
   output logic [lesdp_pkg::VALUE_W-1:0]      wr_data,
   output logic                               res_valid,
   output lesdp_pkg::rsp_type                 res
);

   localparam int VW = lesdp_pkg::VALUE_W;

   logic [VW-1:0]    left_ff, upleft_ff;
   logic [VW-1:0]    best_ff, best_in;
   logic [ROW_W-1:0] best_row_ff, best_row_in;
   logic [COL_W-1:0] best_col_ff, best_col_in;
   logic [VW-1:0]    up;
   logic [VW-1:0]    low;
   logic [VW:0]      grown;
   logic [VW-1:0]    v;

   always_comb begin
      up  = ctl.fwd ? left_ff : rd_data;
      low = left_ff;
      if (up < low) begin
         low = up;
      end
      if (upleft_ff < low) begin
         low = upleft_ff;
      end
      grown = {1'b0, low} + (VW+1)'(1);

      if (!ctl.free) begin
         v = '0;
      end else if (ctl.on_border) begin
         v = VW'(1);
      end else if (grown[VW]) begin
         v = lesdp_pkg::VALUE_MAX;
      end else begin
         v = grown[VW-1:0];
      end

      if (v > best_ff) begin
         best_in     = v;
         best_row_in = row;
         best_col_in = col;
      end else begin
         best_in     = best_ff;
         best_row_in = best_row_ff;
         best_col_in = best_col_ff;
      end
   end

   assign wr_en   = ctl.valid;
   assign wr_addr = col;
   assign wr_data = v;

   assign res_valid     = ctl.valid && ctl.last;
   assign res.best_size = best_in;
   assign res.best_row  = lesdp_pkg::POS_W'(best_row_in);
   assign res.best_col  = lesdp_pkg::POS_W'(best_col_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= '0;
         upleft_ff   <= '0;
         best_ff     <= '0;
         best_row_ff <= '0;
         best_col_ff <= '0;
      end else if (ctl.valid) begin
         left_ff   <= v;
         upleft_ff <= up;
         if (ctl.last) begin
            best_ff     <= '0;
            best_row_ff <= '0;
            best_col_ff <= '0;
         end else begin
            best_ff     <= best_in;
            best_row_ff <= best_row_in;
            best_col_ff <= best_col_in;
         end
      end
   end

endmodule
`default_nettype wire

@@ src/largest_empty_square_dp_core.sv @@
// Top level of the largest empty square finder over a raster stream of cells.
// Throughput: one cell item per cycle unless stalled, set by one line buffer read and write.
// A last-cell item goes through the sequencer registers and the update stage to a result slot.
// Stalls: the input waits only in reset and while the two result slots could overflow.
// Reset is synchronous and clears counters, best square, result slots and row length (to 1);
// the line buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module largest_empty_square_dp_core #(
   parameter int MAX_WIDTH  = lesdp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lesdp_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire lesdp_pkg::req_type            req_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output lesdp_pkg::rsp_type                 rsp_item,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lesdp_pkg::LEN_W-1:0]   csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [lesdp_pkg::LEN_W-1:0]   row_length_ff;
   logic                          accept;
   logic [COL_W-1:0]              rd_addr;
   logic [lesdp_pkg::VALUE_W-1:0] rd_data;
   lesdp_pkg::ctl_type            ctl;
   logic [COL_W-1:0]              col;
   logic [ROW_W-1:0]              row;
   logic                          wr_en;
   logic [COL_W-1:0]              wr_addr;
   logic [lesdp_pkg::VALUE_W-1:0] wr_data;
   logic                          res_valid;
   lesdp_pkg::rsp_type            res;
   logic                          rsp_valid_ff;
   lesdp_pkg::rsp_type            rsp_item_ff;
   logic                          skid_valid_ff;
   lesdp_pkg::rsp_type            skid_item_ff;
   logic                          rsp_pop;

   assign rsp_pop = rsp_valid_ff && rsp_ready;

   // Two result slots hold a result from the update stage and one from an item
   // accepted behind it, so the input only waits when both could be taken.
   assign req_ready = !reset && (skid_valid_ff ? (rsp_ready && !res_valid)
                                               : (!rsp_valid_ff || rsp_ready || !res_valid));
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= lesdp_pkg::ROW_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         row_length_ff <= csr_wdata;
      end
   end

   lesdp_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .COL_W     (COL_W),
      .ROW_W     (ROW_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_item),
      .row_length(row_length_ff),
      .rd_addr   (rd_addr),
      .ctl_ff    (ctl),
      .col_ff    (col),
      .row_ff    (row)
   );

   lesdp_linebuf #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W)
   ) u_linebuf (
      .clock  (clock),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   lesdp_cell #(
      .COL_W(COL_W),
      .ROW_W(ROW_W)
   ) u_cell (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .col      (col),
      .row      (row),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .res_valid(res_valid),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= res_valid;
         end else begin
            rsp_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         if (rsp_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            rsp_item_ff  <= skid_item_ff;
            skid_item_ff <= res;
         end else begin
            rsp_item_ff <= res;
         end
      end else if (res_valid) begin
         if (rsp_valid_ff) begin
            skid_item_ff <= res;
         end else begin
            rsp_item_ff <= res;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

@@ src/lesdp_checker.sv @@
// Port-level checks for the largest empty square finder and their binding.
`timescale 1ns / 1ps
`default_nettype none
module lesdp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire lesdp_pkg::req_type req_item,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire lesdp_pkg::rsp_type rsp_item
);

   // A waiting result holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // An empty grid reports the origin as its position.
   a_empty_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.best_size == '0) |-> (rsp_item.best_row == '0)
         && (rsp_item.best_col == '0))
      else $error("nonzero position reported without a square");

   // A new result comes only from an accepted last-cell item.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_item.last_cell, 2))
      else $error("result item without a last-cell item");

   // With no result waiting, the block always takes an item.
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with no result waiting");

endmodule

bind largest_empty_square_dp_core lesdp_checker u_lesdp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_item (req_item),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_item (rsp_item)
);
`default_nettype wire
